@@ src/assert_macros.svh @@
// Assertion macros used by the top RTL file of the dissipation budget block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define VDB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define VDB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ src/vdb_pkg.sv @@
// Package of the viscous dissipation budget block: payload types, step codes,
// controller/datapath command and status structs. Depends on nothing.
`timescale 1ns / 1ps
package vdb_pkg;

    localparam int          DEF_MAX_CELLS = 1048576;
    localparam logic [31:0] DEF_VISCOSITY = 32'h0001_0000;
    localparam logic [63:0] I64MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64MIN        = 64'h8000_0000_0000_0000;
    // Reciprocal of three scaled by 2^65; exact floor(n / 3) for any n below 2^64.
    localparam logic [63:0] DIV3_RECIP    = 64'hAAAA_AAAA_AAAA_AAAB;

    // Step codes run by the sequencer; each step uses the multiplier or divider.
    localparam logic [4:0] OP_VORT0 = 5'd0;
    localparam logic [4:0] OP_VORT1 = 5'd1;
    localparam logic [4:0] OP_VORT2 = 5'd2;
    localparam logic [4:0] OP_DIVSQ = 5'd3;
    localparam logic [4:0] OP_OFF0  = 5'd4;
    localparam logic [4:0] OP_OFF1  = 5'd5;
    localparam logic [4:0] OP_OFF2  = 5'd6;
    localparam logic [4:0] OP_DIAG0 = 5'd7;
    localparam logic [4:0] OP_DIAG1 = 5'd8;
    localparam logic [4:0] OP_DIAG2 = 5'd9;
    localparam logic [4:0] OP_T1    = 5'd10;
    localparam logic [4:0] OP_T2    = 5'd11;
    localparam logic [4:0] OP_T2DIV = 5'd12;
    localparam logic [4:0] OP_EPS   = 5'd13;
    localparam logic [4:0] OP_OMEAN = 5'd14;
    localparam logic [4:0] OP_DMEAN = 5'd15;
    localparam logic [4:0] OP_RMEAN = 5'd16;
    localparam logic [4:0] OP_NU    = 5'd17;
    localparam logic [4:0] OP_QM    = 5'd18;
    localparam logic [4:0] OP_X3    = 5'd19;
    localparam logic [4:0] OP_X4    = 5'd20;
    localparam logic [4:0] OP_X4DIV = 5'd21;

    typedef struct packed {
        logic signed [31:0] du_dx;
        logic signed [31:0] du_dy;
        logic signed [31:0] du_dz;
        logic signed [31:0] dv_dx;
        logic signed [31:0] dv_dy;
        logic signed [31:0] dv_dz;
        logic signed [31:0] dw_dx;
        logic signed [31:0] dw_dy;
        logic signed [31:0] dw_dz;
        logic        [31:0] density;
        logic               last_cell;
    } t_in;

    typedef struct packed {
        logic        [30:0] mean_vorticity_sq;
        logic        [30:0] mean_divergence_sq;
        logic signed [31:0] total_dissipation;
        logic signed [31:0] solenoidal_dissipation;
        logic signed [31:0] dilatational_dissipation;
        logic        [20:0] cell_count;
    } t_out;

    typedef struct packed {
        logic       load_in;
        logic       mul_start;
        logic       div_start;
        logic       wr;
        logic       acc;
        logic       out_load;
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic emit;
        logic out_free;
    } t_sts;

    // Steps that run on the divider rather than the multiplier.
    function automatic logic is_div_op(input logic [4:0] op);
        is_div_op = op inside {OP_EPS, OP_OMEAN, OP_DMEAN, OP_RMEAN, OP_NU, OP_QM};
    endfunction

endpackage

@@ src/viscous_dissipation_budget_unit.sv @@
// Viscous dissipation budget with a split into solenoidal and dilatational
// parts: one grid cell per item, a result item at the last cell of a run or
// when MAX_CELLS cells have been taken. Each cell is accepted, then runs ten
// squares, two viscosity products and one multiply by the reciprocal of three
// on a 64 x 16 slice multiplier, one pass of the bit-serial divider for the
// division by the cell density, and one accumulate step; no new cell is taken
// before that. The cell that closes a run adds five divisions, three products
// and a load of the result register, plus any wait while the previous result
// is still held. The result register lets the next cell be taken while a
// result waits to leave.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module viscous_dissipation_budget_unit import vdb_pkg::*; #(
    parameter int MAX_CELLS = DEF_MAX_CELLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    vdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Arithmetic and run state.
    vdb_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Checks on sequencing.
    `VDB_ASSERT_NEVER(a_one_unit, i_clk, i_rst_n, cmd.mul_start && cmd.div_start, "both units started")
    `VDB_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready right after accept")
    `VDB_ASSERT(a_no_overwrite, i_clk, i_rst_n, cmd.out_load |-> (!o_out_valid || i_out_ready), "result overwritten")

endmodule

@@ src/vdb_mul.sv @@
// Shared 64 x 64 multiplier, one 64 x 16 partial product per cycle.
// Depends on nothing; used by vdb_datapath.
`timescale 1ns / 1ps
module vdb_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [127:0]  o_prod
);

    logic         r_busy;
    logic         r_done;
    logic [1:0]   r_k;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [15:0]  chunk;
    logic [79:0]  pp;
    logic [127:0] pp_sh;

    // Partial product of the current 16-bit slice, placed at its weight.
    assign chunk = r_b[{r_k, 4'b0000} +: 16];
    assign pp    = {16'b0, r_a} * {64'b0, chunk};
    assign pp_sh = {48'b0, pp} << {r_k, 4'b0000};

    // Control: four slices per product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_done <= r_busy && (r_k == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operands and accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ src/vdb_div.sv @@
// Shared restoring divider, 80-bit dividend by 64-bit divisor, one bit a cycle.
// Depends on nothing; used by vdb_datapath.
`timescale 1ns / 1ps
module vdb_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [79:0]  i_num,
    input  logic [63:0]  i_den,
    output logic         o_done,
    output logic [79:0]  o_quo
);

    localparam int DW   = 80;
    localparam int CNTW = $clog2(DW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [79:0]     r_quo;
    logic [64:0]     r_rem;
    logic [63:0]     r_den;
    logic [64:0]     rem_sh;
    logic            ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_sh = {r_rem[63:0], r_quo[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    // Control: one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNTW'(DW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ src/vdb_datapath.sv @@
// Datapath of the dissipation budget: operand selection, step results, run sums
// and result register. Depends on vdb_pkg, vdb_mul and vdb_div.
`timescale 1ns / 1ps
module vdb_datapath import vdb_pkg::*; #(
    parameter int MAX_CELLS = DEF_MAX_CELLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  t_in         i_in_data,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data
);

    localparam int CW = $clog2(MAX_CELLS + 1);

    t_in                r_in;
    logic [31:0]        r_visc;
    logic [63:0]        r_om2, r_div2, r_off, r_s2, r_t1, r_t2;
    logic signed [63:0] r_tau, r_eps;
    logic [63:0]        r_vsum, r_dsum, r_rsum;
    logic signed [63:0] r_xsum;
    logic [CW-1:0]      r_cells;
    logic [63:0]        r_omean, r_dmean, r_rmean, r_nu, r_qm, r_x4;
    logic [30:0]        r_sol, r_dil;
    t_out               r_out;
    logic               r_out_valid;

    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_p;
    logic         mul_done;
    logic [79:0]  div_n;
    logic [63:0]  div_d;
    logic [79:0]  div_q;
    logic         div_done;

    logic signed [33:0] g_w1, g_w2, g_w3, g_dv, g_o1, g_o2, g_o3;
    logic [63:0]        sqv, capv, tau_mag, xsum_mag, em, nq, third;
    logic [64:0]        g_vs, g_ds, g_rs;
    logic signed [64:0] g_xs;
    logic [63:0]        vs_n, ds_n, rs_n;
    logic signed [63:0] xs_n;

    function automatic logic [63:0] mag34(input logic signed [33:0] x);
        logic signed [33:0] m;
        m = x[33] ? -x : x;
        mag34 = {30'b0, m};
    endfunction

    function automatic logic [30:0] sat31(input logic [63:0] v);
        sat31 = (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
    endfunction

    vdb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    vdb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // Vorticity components, divergence and off-diagonal strain sums of the cell.
    assign g_w1 = 34'(r_in.dw_dy) - 34'(r_in.dv_dz);
    assign g_w2 = 34'(r_in.du_dz) - 34'(r_in.dw_dx);
    assign g_w3 = 34'(r_in.dv_dx) - 34'(r_in.du_dy);
    assign g_dv = 34'(r_in.du_dx) + 34'(r_in.dv_dy) + 34'(r_in.dw_dz);
    assign g_o1 = 34'(r_in.du_dy) + 34'(r_in.dv_dx);
    assign g_o2 = 34'(r_in.du_dz) + 34'(r_in.dw_dx);
    assign g_o3 = 34'(r_in.dv_dz) + 34'(r_in.dw_dy);

    // Product shifted down by 16: plain saturation and saturation at 2^63-1.
    assign sqv  = (|mul_p[127:80]) ? '1 : mul_p[79:16];
    assign capv = (|mul_p[127:80] || mul_p[79]) ? I64MAX : mul_p[79:16];

    // Quotient by three from the product with the scaled reciprocal.
    assign third = {1'b0, mul_p[127:65]};

    assign tau_mag  = r_tau[63] ? (64'd0 - r_tau) : r_tau;
    assign xsum_mag = r_xsum[63] ? (64'd0 - r_xsum) : r_xsum;
    assign em       = (|div_q[79:63]) ? I64MAX : div_q[63:0];
    assign nq       = 64'd0 - r_qm;

    // Operands of the current step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        div_d = 64'd1;
        case (i_cmd.op)
            OP_VORT0: mul_a = mag34(g_w1);
            OP_VORT1: mul_a = mag34(g_w2);
            OP_VORT2: mul_a = mag34(g_w3);
            OP_DIVSQ: mul_a = mag34(g_dv);
            OP_OFF0:  mul_a = mag34(g_o1) >> 1;
            OP_OFF1:  mul_a = mag34(g_o2) >> 1;
            OP_OFF2:  mul_a = mag34(g_o3) >> 1;
            OP_DIAG0: mul_a = mag34(34'(r_in.du_dx));
            OP_DIAG1: mul_a = mag34(34'(r_in.dv_dy));
            OP_DIAG2: mul_a = mag34(34'(r_in.dw_dz));
            OP_T1: begin
                mul_a = {32'b0, r_visc};
                mul_b = r_s2 + {r_off[62:0], 1'b0};
            end
            OP_T2: begin
                mul_a = {32'b0, r_visc};
                mul_b = r_div2;
            end
            OP_T2DIV: begin
                mul_a = {r_t2[62:0], 1'b0};
                mul_b = DIV3_RECIP;
            end
            OP_EPS: begin
                div_n = {tau_mag, 16'b0};
                div_d = (r_in.density == 32'd0) ? 64'd1 : {32'b0, r_in.density};
            end
            OP_OMEAN: begin
                div_n = {16'b0, r_vsum};
                div_d = 64'(r_cells);
            end
            OP_DMEAN: begin
                div_n = {16'b0, r_dsum};
                div_d = 64'(r_cells);
            end
            OP_RMEAN: begin
                div_n = {16'b0, r_rsum};
                div_d = 64'(r_cells);
            end
            OP_NU: begin
                div_n = {32'b0, r_visc, 16'b0};
                div_d = r_rmean;
            end
            OP_QM: begin
                div_n = {16'b0, xsum_mag};
                div_d = 64'(r_cells);
            end
            OP_X3: begin
                mul_a = r_nu;
                mul_b = r_omean;
            end
            OP_X4: begin
                mul_a = r_nu;
                mul_b = r_dmean;
            end
            OP_X4DIV: begin
                mul_a = {r_x4[61:0], 2'b00};
                mul_b = DIV3_RECIP;
            end
            default: begin
                mul_a = '0;
            end
        endcase
        // Squaring steps use the same magnitude on both ports.
        if (i_cmd.op inside {[OP_VORT0:OP_DIAG2]}) begin
            mul_b = mul_a;
        end
    end

    // Step results written back when the shared unit finishes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            case (i_cmd.op)
                OP_VORT0: r_om2 <= sqv;
                OP_VORT1, OP_VORT2: r_om2 <= r_om2 + sqv;
                OP_DIVSQ: r_div2 <= sqv;
                OP_OFF0:  r_off <= sqv;
                OP_OFF1, OP_OFF2: r_off <= r_off + sqv;
                OP_DIAG0: r_s2 <= sqv;
                OP_DIAG1, OP_DIAG2: r_s2 <= r_s2 + sqv;
                OP_T1:    r_t1 <= capv[62] ? I64MAX : {capv[62:0], 1'b0};
                OP_T2:    r_t2 <= capv;
                OP_T2DIV: r_tau <= r_t1 - third;
                OP_EPS:   r_eps <= r_tau[63] ? (64'sd0 - signed'(em)) : signed'(em);
                OP_OMEAN: r_omean <= div_q[63:0];
                OP_DMEAN: r_dmean <= div_q[63:0];
                OP_RMEAN: r_rmean <= (div_q[63:0] == 64'd0) ? 64'd1 : div_q[63:0];
                OP_NU:    r_nu <= div_q[63:0];
                OP_QM:    r_qm <= div_q[63:0];
                OP_X3:    r_sol <= sat31(sqv);
                OP_X4:    r_x4 <= sqv;
                OP_X4DIV: r_dil <= (r_x4 >= 64'h8000_0000) ? 31'h7FFF_FFFF
                                                           : sat31(third);
                default:  r_x4 <= r_x4;
            endcase
        end
    end

    // Saturating updates of the run sums.
    assign g_vs = {1'b0, r_vsum} + {1'b0, r_om2};
    assign g_ds = {1'b0, r_dsum} + {1'b0, r_div2};
    assign g_rs = {1'b0, r_rsum} + {33'b0, r_in.density};
    assign g_xs = 65'(r_xsum) + 65'(r_eps);
    assign vs_n = g_vs[64] ? '1 : g_vs[63:0];
    assign ds_n = g_ds[64] ? '1 : g_ds[63:0];
    assign rs_n = g_rs[64] ? '1 : g_rs[63:0];
    assign xs_n = (g_xs[64] != g_xs[63]) ? (g_xs[64] ? I64MIN : I64MAX) : g_xs[63:0];

    // Run state: accumulate each cell, clear when the result register is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsum  <= '0;
            r_dsum  <= '0;
            r_rsum  <= '0;
            r_xsum  <= '0;
            r_cells <= '0;
        end else if (i_cmd.acc) begin
            r_vsum  <= vs_n;
            r_dsum  <= ds_n;
            r_rsum  <= rs_n;
            r_xsum  <= xs_n;
            r_cells <= r_cells + CW'(1);
        end else if (i_cmd.out_load) begin
            r_vsum  <= '0;
            r_dsum  <= '0;
            r_rsum  <= '0;
            r_xsum  <= '0;
            r_cells <= '0;
        end
    end

    // Viscosity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visc <= DEF_VISCOSITY;
        end else if (i_cfg_we) begin
            r_visc <= i_cfg_wdata;
        end
    end

    // Input item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.mean_vorticity_sq  <= sat31(r_omean);
            r_out.mean_divergence_sq <= sat31(r_dmean);
            if (!r_xsum[63]) begin
                r_out.total_dissipation <= (r_qm > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                                 : signed'(r_qm[31:0]);
            end else begin
                r_out.total_dissipation <= (r_qm > 64'h8000_0000) ? 32'sh8000_0000
                                                                 : signed'(nq[31:0]);
            end
            r_out.solenoidal_dissipation   <= signed'({1'b0, r_sol});
            r_out.dilatational_dissipation <= signed'({1'b0, r_dil});
            r_out.cell_count               <= 21'(r_cells);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Status back to the controller.
    assign o_sts.done     = mul_done | div_done;
    assign o_sts.emit     = r_in.last_cell ||
                            (((CW + 1)'(r_cells) + (CW + 1)'(1)) == (CW + 1)'(MAX_CELLS));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/vdb_ctrl.sv @@
// Sequencer of the dissipation budget: walks the step list per cell and per
// result. Depends on vdb_pkg.
`timescale 1ns / 1ps
module vdb_ctrl import vdb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] CS_IDLE  = 3'd0;
    localparam logic [2:0] CS_ISSUE = 3'd1;
    localparam logic [2:0] CS_WAIT  = 3'd2;
    localparam logic [2:0] CS_ACC   = 3'd3;
    localparam logic [2:0] CS_EMIT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [4:0] r_pc, n_pc;

    // Commands and next state.
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        o_cmd   = '0;
        o_cmd.op = r_pc;
        case (r_state)
            CS_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_pc    = OP_VORT0;
                    n_state = CS_ISSUE;
                end
            end
            CS_ISSUE: begin
                o_cmd.mul_start = !is_div_op(r_pc);
                o_cmd.div_start = is_div_op(r_pc);
                n_state = CS_WAIT;
            end
            CS_WAIT: begin
                o_cmd.wr = i_sts.done;
                if (i_sts.done) begin
                    if (r_pc == OP_EPS) begin
                        n_state = CS_ACC;
                    end else if (r_pc == OP_X4DIV) begin
                        n_state = CS_EMIT;
                    end else begin
                        n_pc    = r_pc + 5'd1;
                        n_state = CS_ISSUE;
                    end
                end
            end
            CS_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.emit) begin
                    n_pc    = OP_OMEAN;
                    n_state = CS_ISSUE;
                end else begin
                    n_state = CS_IDLE;
                end
            end
            CS_EMIT: begin
                o_cmd.out_load = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_pc    <= OP_VORT0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_in_ready = (r_state == CS_IDLE);

endmodule

@@ tb/sv/viscous_dissipation_budget_unit_test.sv @@
// Self-checking testbench of the viscous dissipation budget unit.
// Depends on vdb_pkg and the viscous_dissipation_budget_unit RTL.
// A scoreboard class predicts each run result and checks it against the block.
`timescale 1ns / 1ps
module viscous_dissipation_budget_unit_test;
    import vdb_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam wide_t U64_MAX   = (wide_t'(1) <<< 64) - 1;
    localparam wide_t S64_MAX   = (wide_t'(1) <<< 63) - 1;
    localparam wide_t S64_MIN   = -(wide_t'(1) <<< 63);
    localparam wide_t S31_MAX   = 128'sh7FFF_FFFF;
    localparam wide_t TWO_31    = 128'sh8000_0000;
    localparam int    STALL_LIM = 20000;
    localparam int    HOLD_LEN  = 3000;
    localparam int    SETTLE    = 800;

    // Budget predictor and store of expected run results.
    class budget_scoreboard;
        wide_t visc;
        wide_t vort_sum, div_sum, diss_sum, dens_sum;
        int    cells;
        t_out  budget_q[$];
        int    errors;

        function new();
            visc   = wide_t'(DEF_VISCOSITY);
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            vort_sum = 0;
            div_sum  = 0;
            diss_sum = 0;
            dens_sum = 0;
            cells    = 0;
        endfunction

        function void set_visc(logic [31:0] v);
            visc = wide_t'({1'b0, v});
        endfunction

        function int pending();
            return budget_q.size();
        endfunction

        static function wide_t magn(wide_t x);
            return x < 0 ? -x : x;
        endfunction

        // Q16.16 product, truncated, capped.
        static function wide_t qmul(wide_t a, wide_t b, wide_t cap);
            wide_t r;
            r = (a * b) >>> 16;
            return r > cap ? cap : r;
        endfunction

        static function wide_t qsq(wide_t x);
            return qmul(magn(x), magn(x), U64_MAX);
        endfunction

        static function wide_t uadd(wide_t a, wide_t b);
            return (a + b) > U64_MAX ? U64_MAX : a + b;
        endfunction

        static function wide_t half(wide_t x);
            wide_t m;
            m = magn(x) >>> 1;
            return x < 0 ? -m : m;
        endfunction

        static function wide_t sat31(wide_t x);
            return x > S31_MAX ? S31_MAX : x;
        endfunction

        // Accumulate one accepted cell; a closing cell queues the run result.
        function void note_cell(t_in c);
            wide_t ux, uy, uz, vx, vy, vz, wx, wy, wz, rho, dv;
            wide_t om2, div2, off, s2, t1, t2, tau, em, eps, sum;
            wide_t n, omean, dmean, rmean, nu, qm, x;
            t_out  r;
            ux = wide_t'(c.du_dx); uy = wide_t'(c.du_dy); uz = wide_t'(c.du_dz);
            vx = wide_t'(c.dv_dx); vy = wide_t'(c.dv_dy); vz = wide_t'(c.dv_dz);
            wx = wide_t'(c.dw_dx); wy = wide_t'(c.dw_dy); wz = wide_t'(c.dw_dz);
            rho = wide_t'({1'b0, c.density});
            dv   = ux + vy + wz;
            om2  = uadd(uadd(qsq(wy - vz), qsq(uz - wx)), qsq(vx - uy));
            div2 = qsq(dv);
            off  = uadd(uadd(qsq(half(uy + vx)), qsq(half(uz + wx))), qsq(half(vz + wy)));
            s2   = uadd(uadd(uadd(qsq(ux), qsq(vy)), qsq(wz)), uadd(off, off));
            t1   = qmul(visc, s2, S64_MAX);
            t2   = qmul(visc, div2, S64_MAX);
            t1   = t1 > (S64_MAX >>> 1) ? S64_MAX : t1 * 2;
            t2   = (t2 * 2) / 3;
            tau  = t1 - t2;
            // Zero density divides as the smallest step.
            em   = (magn(tau) <<< 16) / (rho == 0 ? 1 : rho);
            if (em > S64_MAX) em = S64_MAX;
            eps  = tau < 0 ? -em : em;

            vort_sum = uadd(vort_sum, om2);
            div_sum  = uadd(div_sum, div2);
            sum      = diss_sum + eps;
            diss_sum = sum > S64_MAX ? S64_MAX : (sum < S64_MIN ? S64_MIN : sum);
            dens_sum = uadd(dens_sum, rho);
            cells++;
            if (!c.last_cell && cells < DEF_MAX_CELLS) return;

            n     = cells;
            omean = vort_sum / n;
            dmean = div_sum / n;
            rmean = dens_sum / n;
            if (rmean == 0) rmean = 1;
            nu    = (visc <<< 16) / rmean;
            r.mean_vorticity_sq  = 31'(sat31(omean));
            r.mean_divergence_sq = 31'(sat31(dmean));
            qm = magn(diss_sum) / n;
            if (diss_sum >= 0) r.total_dissipation = 32'(qm > S31_MAX ? S31_MAX : qm);
            else r.total_dissipation = 32'(qm > TWO_31 ? TWO_31 : -qm);
            r.solenoidal_dissipation = 32'(sat31(qmul(nu, omean, U64_MAX)));
            x = qmul(nu, dmean, U64_MAX);
            r.dilatational_dissipation = 32'(x >= TWO_31 ? S31_MAX : sat31((x * 4) / 3));
            r.cell_count = 21'(n);
            budget_q.push_back(r);
            clear_sums();
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(t_out got);
            t_out want;
            if (budget_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result item: %p", got);
                return;
            end
            want = budget_q.pop_front();
            if (got.mean_vorticity_sq !== want.mean_vorticity_sq
                || got.mean_divergence_sq !== want.mean_divergence_sq
                || got.total_dissipation !== want.total_dissipation
                || got.solenoidal_dissipation !== want.solenoidal_dissipation
                || got.dilatational_dissipation !== want.dilatational_dissipation
                || got.cell_count !== want.cell_count) begin
                errors++;
                if (errors <= 10) $display("Mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    budget_scoreboard sb = new();
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int stall_cnt;

    viscous_dissipation_budget_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Both handshakes are observed at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_cell(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // Watchdog on cycles with no item moving.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIM) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result receiver with random stalls and a long hold-off under pressure.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [31:0] pick_grad();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3, 4, 5: return $urandom;
            default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_density();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom;
            default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
        endcase
    endfunction

    function automatic t_in random_cell();
        t_in c;
        c.du_dx = pick_grad(); c.du_dy = pick_grad(); c.du_dz = pick_grad();
        c.dv_dx = pick_grad(); c.dv_dy = pick_grad(); c.dv_dz = pick_grad();
        c.dw_dx = pick_grad(); c.dw_dy = pick_grad(); c.dw_dz = pick_grad();
        c.density   = pick_density();
        c.last_cell = ($urandom_range(0, 7) == 0);
        return c;
    endfunction

    function automatic t_in uniform_cell(logic [31:0] g, logic [31:0] rho, logic last);
        t_in c;
        c = '{g, g, g, g, g, g, g, g, g, rho, last};
        return c;
    endfunction

    // Offer one cell and hold it until taken, then maybe leave a gap.
    task automatic send_cell(t_in c);
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Let every expected result arrive and the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_viscosity(logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_visc(v);
    endtask

    task automatic send_random(int count, bit pressure);
        for (int k = 0; k < count; k++) begin
            // Long receiver hold-off while cells keep coming.
            if (pressure && k == 20) hold_left = HOLD_LEN;
            // Sender pause until every result is in.
            if (pressure && k == 70 && sb.pending() > 0) begin
                i_in_valid <= 1'b0;
                while (sb.pending() > 0) @(posedge i_clk);
            end
            send_cell(random_cell());
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_out_ready = 1'b0;
        hold_left   = 0;
        stall_cnt   = 0;
        tx_idle_pct = 14;
        rx_idle_pct = 53;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cells at the reset viscosity: field extremes, zero density,
        // single-cell runs and a longer run.
        send_cell(uniform_cell(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_cell(uniform_cell(32'h8000_0000, 32'h0000_0001, 1'b1));
        send_cell(uniform_cell(32'h0, 32'h0, 1'b1));
        send_cell(uniform_cell(32'h8000_0000, 32'h0, 1'b1));
        send_cell('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h0001_0000, 1'b1});
        send_cell(uniform_cell(32'h0001_0000, 32'h0001_0000, 1'b0));
        send_cell(uniform_cell(32'hFFFF_0000, 32'h0002_0000, 1'b0));
        send_cell(uniform_cell(32'h0000_8000, 32'h0, 1'b1));
        send_cell('{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
                    32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b1});
        send_cell('{32'h0, 32'h0003_0000, 32'h0, 32'hFFFD_0000, 32'h0, 32'h0,
                    32'h0, 32'h0, 32'h0, 32'h0000_8000, 1'b1});
        send_random(125, 1'b0);

        drain();
        write_viscosity(32'h0);
        tx_idle_pct = 53;
        rx_idle_pct = 14;
        send_cell(uniform_cell(32'h7FFF_FFFF, 32'h0001_0000, 1'b1));
        send_random(125, 1'b0);

        drain();
        write_viscosity(32'hFFFF_FFFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_cell(uniform_cell(32'h7FFF_FFFF, 32'h0000_0001, 1'b1));
        send_cell(uniform_cell(32'h0000_4000, 32'h0, 1'b1));
        send_random(125, 1'b1);

        drain();
        write_viscosity($urandom);
        send_random(125, 1'b0);
        send_cell(uniform_cell(32'h0000_1000, 32'h0001_0000, 1'b1));

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ viscous_dissipation_budget_unit.f @@
+incdir+src
src/vdb_pkg.sv
src/vdb_mul.sv
src/vdb_div.sv
src/vdb_datapath.sv
src/vdb_ctrl.sv
src/viscous_dissipation_budget_unit.sv
tb/sv/viscous_dissipation_budget_unit_test.sv
